@@ hdl/rmsacc_pkg.sv @@
// rmsacc_pkg: shared types, widths and codes for the RMS / mean accumulator.
// Used by every module under hdl/. No dependencies.
package rmsacc_pkg;

   localparam int CHANNELS  = 8;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_W      = 4;
   localparam int CMD_W     = 2;
   localparam int SMP_W     = 12;
   localparam int OFF_W     = 13;
   localparam int GAIN_W    = 24;
   localparam int CNT_W     = 16;
   localparam int SQ_W      = 44;
   localparam int SUM_W     = 31;
   localparam int DELTA_W   = 14;
   localparam int PROD_W    = 2 * DELTA_W;
   localparam int ROOT_W    = SQ_W / 2;
   localparam int OUT_W     = 21;
   localparam int STEP_W    = 6;
   localparam int FRAC_W    = 16;
   localparam int RMS_P_W   = ROOT_W + 1 + GAIN_W;
   localparam int MEAN_P_W  = SUM_W + GAIN_W;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(CHANNELS - 1);
   localparam logic [GAIN_W-1:0]   UNITY_GAIN = GAIN_W'(65536);
   localparam logic [STEP_W-1:0]   DIV_LAST_STEP  = STEP_W'(SQ_W - 1);
   localparam logic [STEP_W-1:0]   ROOT_LAST_STEP = STEP_W'(ROOT_W - 1);
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // input command codes
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CAL    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;  // unused, dropped

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_CAL,
      OP_CLEAR
   } op_type;

   // one classified item in the queue
   typedef struct packed {
      op_type                     op;
      logic [CH_IDX_W-1:0]        channel;
      logic [SMP_W-1:0]           sample;
      logic signed [OFF_W-1:0]    offset;
      logic signed [GAIN_W-1:0]   gain;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACC,
      ST_LOAD_SQ,
      ST_DIV_SQ,
      ST_LOAD_ROOT,
      ST_ROOT,
      ST_LOAD_MEAN,
      ST_DIV_MEAN,
      ST_MUL,
      ST_SCALE,
      ST_OUT
   } state_type;

endpackage

@@ hdl/rms_mean_channel_accumulator_top.sv @@
// rms_mean_channel_accumulator_top: top level, front -> queue -> back.
// Depends on rmsacc_pkg, rmsacc_front, rmsacc_queue, rmsacc_back.
//
//  channel  direction  handshake                 payload
//  req      in         req_valid / req_ready     command, channel, sample, cal_offset, cal_gain
//  rsp      out        rsp_valid / rsp_ready     out_channel, rms_value, mean_value, last
//  csr      in         csr_write_en              csr_write_data (window_scans)
//
// A sample passes the back as dequeue, square and accumulate; calibration and clear act at dequeue.
// At window end each channel runs through the shared bit-serial
// divider (44 steps, twice) and the square root unit (22 steps), then waits for rsp_ready.
// Reset is synchronous: sums and scan count zero, gains unity, window 100.
// Front hold and 2-entry queue take beats while the back is busy or rsp stalls, until both fill.
module rms_mean_channel_accumulator_top import rmsacc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [CH_W-1:0]          req_channel,
   input  logic [SMP_W-1:0]         req_sample,
   input  logic signed [OFF_W-1:0]  req_cal_offset,
   input  logic signed [GAIN_W-1:0] req_cal_gain,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CH_W-1:0]          rsp_out_channel,
   output logic signed [OUT_W-1:0]  rsp_rms_value,
   output logic signed [OUT_W-1:0]  rsp_mean_value,
   output logic                     rsp_last,
   input  logic                     csr_write_en,
   input  logic [CNT_W-1:0]         csr_write_data
);
   logic      push, q_full, q_not_empty, q_pop;
   entry_type push_data, q_data;

   rmsacc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_channel    (req_channel),
      .req_sample     (req_sample),
      .req_cal_offset (req_cal_offset),
      .req_cal_gain   (req_cal_gain),
      .push           (push),
      .push_data      (push_data),
      .queue_full     (q_full)
   );

   rmsacc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   rmsacc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_rms_value   (rsp_rms_value),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_last        (rsp_last)
   );

endmodule

@@ hdl/rmsacc_queue.sv @@
// rmsacc_queue: short FIFO of classified items between front and back.
// Depends on rmsacc_pkg.
module rmsacc_queue import rmsacc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_data
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   entry_type             slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slots_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // slot storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/rmsacc_front.sv @@
// rmsacc_front: accepts request beats, drops unused ones, holds one classified item.
// Depends on rmsacc_pkg; feeds rmsacc_queue.
module rmsacc_front import rmsacc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [CH_W-1:0]          req_channel,
   input  logic [SMP_W-1:0]         req_sample,
   input  logic signed [OFF_W-1:0]  req_cal_offset,
   input  logic signed [GAIN_W-1:0] req_cal_gain,
   output logic                     push,
   output entry_type                push_data,
   input  logic                     queue_full
);
   logic      hold_valid_ff, hold_valid_in;
   entry_type hold_ff, hold_in;
   logic      accept, keep, ch_ok;

   assign push      = hold_valid_ff;
   assign push_data = hold_ff;
   assign req_ready = !hold_valid_ff || !queue_full;
   assign accept    = req_valid && req_ready;
   assign ch_ok     = ({1'b0, req_channel} < (CH_W+1)'(CHANNELS));

   // classify: clear always kept, sample and calibration only on a real channel
   always_comb begin
      hold_in         = hold_ff;
      hold_in.channel = req_channel[CH_IDX_W-1:0];
      hold_in.sample  = req_sample;
      hold_in.offset  = req_cal_offset;
      hold_in.gain    = req_cal_gain;
      keep            = 1'b0;
      case (req_command)
         CMD_SAMPLE: begin
            hold_in.op = OP_SAMPLE;
            keep       = ch_ok;
         end
         CMD_CAL: begin
            hold_in.op = OP_CAL;
            keep       = ch_ok;
         end
         CMD_CLEAR: begin
            hold_in.op = OP_CLEAR;
            keep       = 1'b1;
         end
         default: begin
            hold_in.op = OP_CLEAR;
            keep       = 1'b0;
         end
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (hold_valid_ff && !queue_full) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

endmodule

@@ hdl/rmsacc_back.sv @@
// rmsacc_back: accumulates samples, and at window end runs divide, square root
// and gain scaling per channel. Depends on rmsacc_pkg; reads rmsacc_queue.
module rmsacc_back import rmsacc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_not_empty,
   input  entry_type                q_data,
   output logic                     q_pop,
   input  logic                     csr_write_en,
   input  logic [CNT_W-1:0]         csr_write_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CH_W-1:0]          rsp_out_channel,
   output logic signed [OUT_W-1:0]  rsp_rms_value,
   output logic signed [OUT_W-1:0]  rsp_mean_value,
   output logic                     rsp_last
);
   state_type state_ff, state_in;

   // per-channel state
   logic [SQ_W-1:0]          sq_sums_ff [CHANNELS];
   logic [SQ_W-1:0]          sq_sums_in [CHANNELS];
   logic signed [SUM_W-1:0]  plain_ff   [CHANNELS];
   logic signed [SUM_W-1:0]  plain_in   [CHANNELS];
   logic signed [OFF_W-1:0]  offset_ff  [CHANNELS];
   logic signed [OFF_W-1:0]  offset_in  [CHANNELS];
   logic signed [GAIN_W-1:0] gain_ff    [CHANNELS];
   logic signed [GAIN_W-1:0] gain_in    [CHANNELS];
   logic [CNT_W-1:0]         scan_ff, scan_in, scan_next;
   logic [CNT_W-1:0]         window_ff, window_in;

   // working registers
   entry_type                cur_ff, cur_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [PROD_W-1:0]        sq_ff, sq_in;
   logic [CH_IDX_W-1:0]      idx_ff, idx_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [SQ_W-1:0]          div_q_ff, div_q_in;
   logic [CNT_W-1:0]         div_r_ff, div_r_in;
   logic [SQ_W-1:0]          root_v_ff, root_v_in;
   logic [SQ_W:0]            root_r_ff, root_r_in;
   logic [SQ_W-1:0]          root_b_ff, root_b_in;
   logic [ROOT_W-1:0]        rms_ff, rms_in;
   logic                     mean_neg_ff, mean_neg_in;
   logic signed [RMS_P_W-1:0]  rms_p_ff, rms_p_in;
   logic signed [MEAN_P_W-1:0] mean_p_ff, mean_p_in;
   logic [CH_W-1:0]          o_ch_ff, o_ch_in;
   logic signed [OUT_W-1:0]  o_rms_ff, o_rms_in, o_mean_ff, o_mean_in;
   logic                     o_last_ff, o_last_in;

   // shared step logic
   logic [CNT_W:0]           div_t, div_diff;
   logic                     div_ge;
   logic [SQ_W:0]            root_sum;
   logic                     root_ge;
   logic signed [DELTA_W-1:0] delta_c;
   logic signed [SUM_W-1:0]  mean_c;
   logic [SUM_W-1:0]         plain_abs;
   logic signed [RMS_P_W-FRAC_W-1:0]  rms_sh;
   logic signed [MEAN_P_W-FRAC_W-1:0] mean_sh;
   logic                     scan_end, win_hit, out_take;

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_out_channel = o_ch_ff;
   assign rsp_rms_value   = o_rms_ff;
   assign rsp_mean_value  = o_mean_ff;
   assign rsp_last        = o_last_ff;
   assign q_pop           = (state_ff == ST_IDLE) && q_not_empty;
   assign out_take        = rsp_valid && rsp_ready;

   // restoring divide step, one quotient bit a cycle
   assign div_t    = {div_r_ff, div_q_ff[SQ_W-1]};
   assign div_diff = div_t - {1'b0, scan_ff};
   assign div_ge   = (div_t >= {1'b0, scan_ff});

   // digit-by-digit square root step
   assign root_sum = root_r_ff + {1'b0, root_b_ff};
   assign root_ge  = ({1'b0, root_v_ff} >= root_sum);

   assign delta_c   = $signed({2'b00, cur_ff.sample}) - DELTA_W'(offset_ff[cur_ff.channel]);
   assign plain_abs = plain_ff[idx_ff][SUM_W-1] ? SUM_W'(-plain_ff[idx_ff])
                                                : SUM_W'(plain_ff[idx_ff]);
   assign mean_c    = mean_neg_ff ? -$signed(div_q_ff[SUM_W-1:0])
                                  : $signed(div_q_ff[SUM_W-1:0]);
   assign rms_sh    = (RMS_P_W-FRAC_W)'(rms_p_ff >>> FRAC_W);
   assign mean_sh   = (MEAN_P_W-FRAC_W)'(mean_p_ff >>> FRAC_W);

   // scan counter wraps past zero to one
   assign scan_next = (scan_ff == {CNT_W{1'b1}}) ? CNT_W'(1) : scan_ff + 1'b1;
   assign scan_end  = (cur_ff.channel == LAST_CH);
   assign win_hit   = scan_end && (scan_next >= window_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (q_not_empty && q_data.op == OP_SAMPLE) state_in = ST_SQUARE;
         ST_SQUARE:    state_in = ST_ACC;
         ST_ACC:       state_in = win_hit ? ST_LOAD_SQ : ST_IDLE;
         ST_LOAD_SQ:   state_in = ST_DIV_SQ;
         ST_DIV_SQ:    if (step_ff == DIV_LAST_STEP) state_in = ST_LOAD_ROOT;
         ST_LOAD_ROOT: state_in = ST_ROOT;
         ST_ROOT:      if (step_ff == ROOT_LAST_STEP) state_in = ST_LOAD_MEAN;
         ST_LOAD_MEAN: state_in = ST_DIV_MEAN;
         ST_DIV_MEAN:  if (step_ff == DIV_LAST_STEP) state_in = ST_MUL;
         ST_MUL:       state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_OUT;
         ST_OUT:       if (rsp_ready) state_in = (idx_ff == LAST_CH) ? ST_IDLE : ST_LOAD_SQ;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      sq_sums_in  = sq_sums_ff;
      plain_in    = plain_ff;
      offset_in   = offset_ff;
      gain_in     = gain_ff;
      scan_in     = scan_ff;
      window_in   = csr_write_en ? csr_write_data : window_ff;
      cur_in      = cur_ff;
      delta_in    = delta_ff;
      sq_in       = sq_ff;
      idx_in      = idx_ff;
      step_in     = step_ff;
      div_q_in    = div_q_ff;
      div_r_in    = div_r_ff;
      root_v_in   = root_v_ff;
      root_r_in   = root_r_ff;
      root_b_in   = root_b_ff;
      rms_in      = rms_ff;
      mean_neg_in = mean_neg_ff;
      rms_p_in    = rms_p_ff;
      mean_p_in   = mean_p_ff;
      o_ch_in     = o_ch_ff;
      o_rms_in    = o_rms_ff;
      o_mean_in   = o_mean_ff;
      o_last_in   = o_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               cur_in = q_data;
               case (q_data.op)
                  OP_CAL: begin
                     offset_in[q_data.channel] = q_data.offset;
                     gain_in[q_data.channel]   = q_data.gain;
                  end
                  OP_CLEAR: begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        sq_sums_in[i] = '0;
                        plain_in[i]   = '0;
                     end
                     scan_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SQUARE: begin
            delta_in = delta_c;
            sq_in    = PROD_W'(delta_c) * PROD_W'(delta_c);
         end
         ST_ACC: begin
            sq_sums_in[cur_ff.channel] = sq_sums_ff[cur_ff.channel] + SQ_W'(sq_ff);
            plain_in[cur_ff.channel]   = plain_ff[cur_ff.channel] + SUM_W'(delta_ff);
            if (scan_end) begin
               scan_in = scan_next;
            end
            idx_in = '0;
         end
         ST_LOAD_SQ: begin
            div_q_in = sq_sums_ff[idx_ff];
            div_r_in = '0;
            step_in  = '0;
         end
         ST_DIV_SQ, ST_DIV_MEAN: begin
            div_r_in = div_ge ? div_diff[CNT_W-1:0] : div_t[CNT_W-1:0];
            div_q_in = {div_q_ff[SQ_W-2:0], div_ge};
            step_in  = step_ff + 1'b1;
         end
         ST_LOAD_ROOT: begin
            root_v_in = div_q_ff;
            root_r_in = '0;
            root_b_in = SQ_W'(1) << (SQ_W - 2);
            step_in   = '0;
         end
         ST_ROOT: begin
            if (root_ge) begin
               root_v_in = root_v_ff - root_sum[SQ_W-1:0];
               root_r_in = (root_r_ff >> 1) + {1'b0, root_b_ff};
            end else begin
               root_r_in = root_r_ff >> 1;
            end
            root_b_in = root_b_ff >> 2;
            step_in   = step_ff + 1'b1;
         end
         ST_LOAD_MEAN: begin
            rms_in      = root_r_ff[ROOT_W-1:0];
            mean_neg_in = plain_ff[idx_ff][SUM_W-1];
            div_q_in    = SQ_W'(plain_abs);
            div_r_in    = '0;
            step_in     = '0;
         end
         ST_MUL: begin
            rms_p_in  = $signed({1'b0, rms_ff}) * gain_ff[idx_ff];
            mean_p_in = mean_c * gain_ff[idx_ff];
         end
         ST_SCALE: begin
            o_ch_in   = CH_W'(idx_ff);
            o_last_in = (idx_ff == LAST_CH);
            if (rms_sh > OUT_MAX)       o_rms_in = OUT_MAX;
            else if (rms_sh < OUT_MIN)  o_rms_in = OUT_MIN;
            else                        o_rms_in = OUT_W'(rms_sh);
            if (mean_sh > OUT_MAX)      o_mean_in = OUT_MAX;
            else if (mean_sh < OUT_MIN) o_mean_in = OUT_MIN;
            else                        o_mean_in = OUT_W'(mean_sh);
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (idx_ff == LAST_CH) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     sq_sums_in[i] = '0;
                     plain_in[i]   = '0;
                  end
                  scan_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control and table state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_ff   <= '0;
         window_ff <= CNT_W'(100);
         for (int i = 0; i < CHANNELS; i++) begin
            sq_sums_ff[i] <= '0;
            plain_ff[i]   <= '0;
            offset_ff[i]  <= '0;
            gain_ff[i]    <= UNITY_GAIN;
         end
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         window_ff  <= window_in;
         sq_sums_ff <= sq_sums_in;
         plain_ff   <= plain_in;
         offset_ff  <= offset_in;
         gain_ff    <= gain_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      delta_ff    <= delta_in;
      sq_ff       <= sq_in;
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      root_v_ff   <= root_v_in;
      root_r_ff   <= root_r_in;
      root_b_ff   <= root_b_in;
      rms_ff      <= rms_in;
      mean_neg_ff <= mean_neg_in;
      rms_p_ff    <= rms_p_in;
      mean_p_ff   <= mean_p_in;
      o_ch_ff     <= o_ch_in;
      o_rms_ff    <= o_rms_in;
      o_mean_ff   <= o_mean_in;
      o_last_ff   <= o_last_in;
   end

   // divider never sees a zero scan count
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_SQ || state_ff == ST_DIV_MEAN) |-> scan_ff != '0)
      else $error("divide with zero scan count");

   // remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_SQ || state_ff == ST_DIV_MEAN) |-> div_r_ff < scan_ff)
      else $error("divider remainder out of range");

   // a result beat follows the scale stage
   a_rsp_after_scale: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_SCALE)
      else $error("result without scale stage");

   // sums clear once the last result of a window is taken
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (out_take && rsp_last) |=> scan_ff == '0)
      else $error("scan count not cleared after window");

endmodule

@@ test/testbench.sv @@
// testbench: self-checking bench for rms_mean_channel_accumulator_top.
// Depends on rmsacc_pkg and the block's RTL; per-channel sums predicted locally.
`timescale 1ns / 100ps

// Per-channel RMS/mean predictor and queue of expected result beats
class rms_scoreboard;
   typedef struct {
      logic [3:0]         chan;
      logic signed [20:0] rms;
      logic signed [20:0] mean;
      logic               last;
   } result_beat;

   result_beat            expected_beats[$];
   logic [43:0]           square_sums[rmsacc_pkg::CHANNELS];
   logic signed [30:0]    plain_sums[rmsacc_pkg::CHANNELS];
   logic signed [12:0]    offsets[rmsacc_pkg::CHANNELS];
   logic signed [23:0]    gains[rmsacc_pkg::CHANNELS];
   logic [15:0]           scan_count;
   logic [15:0]           window_scans;
   int                    mismatches;

   function new();
      mismatches   = 0;
      window_scans = 16'd100;
      clear_sums();
      for (int i = 0; i < rmsacc_pkg::CHANNELS; i++) begin
         offsets[i] = '0;
         gains[i]   = 24'sd65536;
      end
   endfunction

   function void clear_sums();
      for (int i = 0; i < rmsacc_pkg::CHANNELS; i++) begin
         square_sums[i] = '0;
         plain_sums[i]  = '0;
      end
      scan_count = '0;
   endfunction

   function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
      return r;
   endfunction

   // multiply by Q8.16 gain, floor shift, saturate to 21 bits
   function logic signed [20:0] apply_gain(longint value, longint gain);
      longint p;
      longint q;
      p = value * gain;
      q = p >>> 16;
      if (q > 1048575) q = 1048575;
      if (q < -1048576) q = -1048576;
      return q[20:0];
   endfunction

   function void note_request(logic [1:0] cmd, logic [3:0] chan, logic [11:0] smp,
                              logic signed [12:0] off, logic signed [23:0] gain);
      longint     delta;
      longint     n;
      logic [15:0] eff_window;
      result_beat beat;
      if (cmd == rmsacc_pkg::CMD_CLEAR) begin
         clear_sums();
         return;
      end
      if (cmd != rmsacc_pkg::CMD_SAMPLE && cmd != rmsacc_pkg::CMD_CAL) return;
      if (chan >= rmsacc_pkg::CHANNELS) return;
      if (cmd == rmsacc_pkg::CMD_CAL) begin
         offsets[chan] = off;
         gains[chan]   = gain;
         return;
      end
      delta = longint'(smp) - longint'(offsets[chan]);
      square_sums[chan] = square_sums[chan] + 44'(delta * delta);
      plain_sums[chan]  = plain_sums[chan] + 31'(delta);
      if (chan != rmsacc_pkg::CHANNELS - 1) return;
      scan_count = scan_count + 16'd1;
      if (scan_count == 0) scan_count = 16'd1;
      eff_window = (window_scans == 0) ? 16'd1 : window_scans;
      if (scan_count < eff_window) return;
      n = scan_count;
      for (int i = 0; i < rmsacc_pkg::CHANNELS; i++) begin
         beat.chan = 4'(i);
         beat.rms  = apply_gain(longint'(int_sqrt(64'(square_sums[i]) / n)), gains[i]);
         beat.mean = apply_gain(longint'(plain_sums[i]) / n, gains[i]);
         beat.last = (i == rmsacc_pkg::CHANNELS - 1);
         expected_beats.push_back(beat);
      end
      clear_sums();
   endfunction

   function void report(string what);
      $display("mismatch: %s", what);
      mismatches++;
   endfunction

   function void check_result(logic [3:0] chan, logic signed [20:0] rms,
                              logic signed [20:0] mean, logic last);
      result_beat beat;
      if (expected_beats.size() == 0) begin
         report($sformatf("unexpected beat ch %0d", chan));
         return;
      end
      beat = expected_beats.pop_front();
      if (chan !== beat.chan) report($sformatf("channel %0d want %0d", chan, beat.chan));
      if (rms !== beat.rms)
         report($sformatf("ch %0d rms %0d want %0d", beat.chan, rms, beat.rms));
      if (mean !== beat.mean)
         report($sformatf("ch %0d mean %0d want %0d", beat.chan, mean, beat.mean));
      if (last !== beat.last) report($sformatf("ch %0d last %0b", beat.chan, last));
   endfunction
endclass

module testbench;
   import rmsacc_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command;
   logic [CH_W-1:0]          req_channel;
   logic [SMP_W-1:0]         req_sample;
   logic signed [OFF_W-1:0]  req_cal_offset;
   logic signed [GAIN_W-1:0] req_cal_gain;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [CH_W-1:0]          rsp_out_channel;
   logic signed [OUT_W-1:0]  rsp_rms_value;
   logic signed [OUT_W-1:0]  rsp_mean_value;
   logic                     rsp_last;
   logic                     csr_write_en;
   logic [CNT_W-1:0]         csr_write_data;

   rms_scoreboard board;
   int            send_idle_pct;
   int            stall_pct;

   rms_mean_channel_accumulator_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // result side: random stall, check each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_out_channel, rsp_rms_value, rsp_mean_value, rsp_last);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one request beat; idle gaps drop valid before the next beat is raised
   task automatic send_beat(logic [1:0] cmd, logic [3:0] chan, logic [11:0] smp,
                            logic signed [12:0] off, logic signed [23:0] gain);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_channel    <= chan;
      req_sample     <= smp;
      req_cal_offset <= off;
      req_cal_gain   <= gain;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(cmd, chan, smp, off, gain);
   endtask

   // stop sending and wait for every expected result
   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_beats.size() != 0) @(posedge clock);
   endtask

   task automatic drain();
      wait_results();
      repeat (3000) @(posedge clock);
   endtask

   task automatic write_window(logic [15:0] value);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      board.window_scans = value;
   endtask

   task automatic random_sample(logic [3:0] chan);
      logic [11:0] smp;
      case ($urandom_range(3))
         0: smp = 12'd0;
         1: smp = 12'hFFF;
         default: smp = 12'($urandom);
      endcase
      send_beat(CMD_SAMPLE, chan, smp, 13'($urandom), 24'($urandom));
   endtask

   task automatic random_cal();
      logic signed [23:0] gain;
      case ($urandom_range(3))
         0: gain = 24'sd65536;
         1: gain = 24'($urandom);
         2: gain = 24'($urandom_range(200000)) - 24'sd100000;
         default: gain = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      endcase
      send_beat(CMD_CAL, 4'($urandom_range(CHANNELS - 1)), 12'($urandom),
                13'($urandom), gain);
   endtask

   // a full scan with random content, sometimes a noise beat mixed in
   task automatic random_scan();
      for (int c = 0; c < CHANNELS; c++) begin
         if ($urandom_range(19) == 0) begin
            case ($urandom_range(3))
               0: send_beat(CMD_NONE, 4'($urandom), 12'($urandom), 13'($urandom),
                            24'($urandom));
               1: send_beat(CMD_SAMPLE, 4'($urandom_range(15, CHANNELS)), 12'($urandom),
                            13'($urandom), 24'($urandom));
               2: random_cal();
               default: random_sample(4'($urandom_range(CHANNELS - 1)));
            endcase
         end
         random_sample(4'(c));
      end
   endtask

   initial begin
      board          = new();
      send_idle_pct  = 0;
      stall_pct      = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_SAMPLE;
      req_channel    = '0;
      req_sample     = '0;
      req_cal_offset = '0;
      req_cal_gain   = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: window of zero, extremes, every command, odd channels
      write_window(16'd0);
      send_beat(CMD_CAL, 4'd0, 12'd0, 13'sh0FFF, 24'sh7FFFFF);
      send_beat(CMD_CAL, 4'd1, 12'd0, -13'sd4096, 24'sh800000);
      send_beat(CMD_CAL, 4'd15, 12'd0, 13'sd5, 24'sd3);
      send_beat(CMD_NONE, 4'd2, 12'hFFF, 13'sd1, 24'sd1);
      send_beat(CMD_SAMPLE, 4'd9, 12'hFFF, 13'sd0, 24'sd0);
      for (int c = 0; c < CHANNELS; c++)
         send_beat(CMD_SAMPLE, 4'(c), (c % 2) ? 12'hFFF : 12'd0, 13'sd0, 24'sd0);
      send_beat(CMD_SAMPLE, 4'd3, 12'h800, 13'sd0, 24'sd0);
      send_beat(CMD_CLEAR, 4'd0, 12'd0, 13'sd0, 24'sd0);
      // mid-run lower: scan count already past the window
      write_window(16'd3);
      random_scan();
      random_scan();
      write_window(16'd1);
      random_scan();
      write_window(16'hFFFF);
      random_scan();
      send_beat(CMD_CLEAR, 4'd0, 12'd0, 13'sd0, 24'sd0);
      write_window(16'd2);

      // random phases with different idling mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         write_window(16'($urandom_range(1, 3)));
         for (int s = 0; s < 10; s++) begin
            if ($urandom_range(5) == 0) random_cal();
            if ($urandom_range(29) == 0)
               send_beat(CMD_CLEAR, 4'($urandom), 12'($urandom), 13'($urandom), 24'($urandom));
            random_scan();
            if (s == 5) wait_results();
         end
      end

      drain();
      if (board.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
